### design/qpie_pkg.sv
// ----------------------------------------------------------------------------
// qpie_pkg
// Shared types and character constants for the query parameter extractor.
// ----------------------------------------------------------------------------
package qpie_pkg;

    localparam int KEY_LENGTH_W = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int MAG_W        = 30;
    localparam int VALUE_W      = 31;

    typedef enum logic [0:0] {
        CFG_KEY_LENGTH = 1'b0,
        CFG_KEY_BYTES  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_BLANK  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_STOP   = 4'b1000
    } phase_t;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] param_value;
        logic                      key_found;
    } out_item_t;

endpackage

### design/query_param_int_extractor.sv
// ----------------------------------------------------------------------------
// query_param_int_extractor
// Streams a query string one byte per item and returns the decoded integer of
// the first '&' segment that starts with the configured key and '='. Each
// byte waits in the input register and is folded into the segment and
// number state by a single compare and multiply-by-ten step, so one byte is
// accepted every cycle unless a last byte is waiting in the input register.
// The item that carries the last byte yields one result item whose valid is
// registered when the parser takes that byte from the input register, and
// the next string can follow immediately. A last byte waits in the input
// register only while the previous result is still held at the output.
// Program key_length and key_bytes only while no string is in progress.
// ----------------------------------------------------------------------------
module query_param_int_extractor #(
    parameter int KEY_MAX_BYTES   = 8,
    parameter int VALUE_MAX_BYTES = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  qpie_pkg::cfg_index_t              cfg_index,
    input  logic [qpie_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  qpie_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output qpie_pkg::out_item_t               out_item
);

    logic [qpie_pkg::KEY_LENGTH_W-1:0] key_length_reg;
    logic [KEY_MAX_BYTES*8-1:0]        key_bytes_reg;

    logic               hold_valid;
    logic               hold_take;
    qpie_pkg::in_item_t hold_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            key_bytes_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                qpie_pkg::CFG_KEY_LENGTH:
                begin
                    key_length_reg <= cfg_data[qpie_pkg::KEY_LENGTH_W-1:0];
                end
                qpie_pkg::CFG_KEY_BYTES:
                begin
                    key_bytes_reg <= cfg_data[KEY_MAX_BYTES*8-1:0];
                end
                default:
                begin
                    key_length_reg <= key_length_reg;
                end
            endcase
        end
    end

    qpie_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .hold_valid (hold_valid),
        .hold_take  (hold_take),
        .hold_item  (hold_item)
    );

    qpie_parse #(
        .KEY_MAX_BYTES   (KEY_MAX_BYTES),
        .VALUE_MAX_BYTES (VALUE_MAX_BYTES)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_length (key_length_reg),
        .key_bytes  (key_bytes_reg),
        .hold_valid (hold_valid),
        .hold_take  (hold_take),
        .hold_item  (hold_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

### design/qpie_in_stage.sv
// ----------------------------------------------------------------------------
// qpie_in_stage
// Input holding register; accepts a new item whenever it is empty or the held one moves on.
// ----------------------------------------------------------------------------
module qpie_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qpie_pkg::in_item_t in_item,
    output logic               hold_valid,
    input  logic               hold_take,
    output qpie_pkg::in_item_t hold_item
);

    logic               valid_reg;
    qpie_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || hold_take;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### design/qpie_parse.sv
// ----------------------------------------------------------------------------
// qpie_parse
// Per-byte segment matcher and decimal accumulator, plus the result register.
// ----------------------------------------------------------------------------
module qpie_parse #(
    parameter int KEY_MAX_BYTES   = 8,
    parameter int VALUE_MAX_BYTES = 9
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [qpie_pkg::KEY_LENGTH_W-1:0]     key_length,
    input  logic [KEY_MAX_BYTES*8-1:0]            key_bytes,
    input  logic                                  hold_valid,
    output logic                                  hold_take,
    input  qpie_pkg::in_item_t                    hold_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output qpie_pkg::out_item_t                   out_item
);

    localparam int SEG_W = $clog2(KEY_MAX_BYTES + 2);
    localparam int CNT_W = $clog2(VALUE_MAX_BYTES + 2);
    localparam logic [SEG_W-1:0] KMAX = SEG_W'(KEY_MAX_BYTES);
    localparam logic [CNT_W-1:0] VMAX = CNT_W'(VALUE_MAX_BYTES);
    localparam int VALUE_W_L = qpie_pkg::VALUE_W;

    logic [SEG_W-1:0]             seg_reg, seg_next;
    logic                         pm_reg, pm_next;
    logic                         inval_reg, inval_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    qpie_pkg::phase_t             phase_reg, phase_next;
    logic                         neg_reg, neg_next;
    logic [qpie_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic                         done_reg, done_next;
    logic                         out_valid_reg;
    qpie_pkg::out_item_t          out_item_reg, out_item_next;

    logic [7:0]                   c;
    logic [SEG_W-1:0]             klen;
    logic [7:0]                   kbyte;
    logic                         digit;
    logic                         blank;
    logic [VALUE_W_L-1:0]         mag_ext;

    assign c     = hold_item.query_byte;
    assign digit = (c >= qpie_pkg::CH_ZERO) && (c <= qpie_pkg::CH_NINE);
    assign blank = (c == qpie_pkg::CH_SPACE) ||
                   ((c >= qpie_pkg::CH_TAB) && (c <= qpie_pkg::CH_CR));

    assign hold_take = hold_valid && (!hold_item.last_byte || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        if ({{(32-qpie_pkg::KEY_LENGTH_W){1'b0}}, key_length} > 32'(KEY_MAX_BYTES))
        begin
            klen = KMAX;
        end
        else
        begin
            klen = SEG_W'(key_length);
        end
    end

    always_comb
    begin
        kbyte = 8'h00;
        for (int i = 0; i < KEY_MAX_BYTES; i++)
        begin
            if (seg_reg == SEG_W'(i))
            begin
                kbyte = key_bytes[i*8 +: 8];
            end
        end
    end

    always_comb
    begin
        seg_next   = seg_reg;
        pm_next    = pm_reg;
        inval_next = inval_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        done_next  = done_reg;
        if (!done_reg)
        begin
            if (c == qpie_pkg::CH_AMP)
            begin
                if (inval_reg)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    seg_next = '0;
                    pm_next  = 1'b1;
                end
            end
            else if (inval_reg)
            begin
                if (cnt_reg <= VMAX)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (cnt_reg < VMAX)
                begin
                    unique case (phase_reg)
                        qpie_pkg::PH_BLANK:
                        begin
                            if (blank)
                            begin
                                phase_next = qpie_pkg::PH_BLANK;
                            end
                            else if (c == qpie_pkg::CH_PLUS || c == qpie_pkg::CH_MINUS)
                            begin
                                neg_next   = (c == qpie_pkg::CH_MINUS);
                                phase_next = qpie_pkg::PH_SIGN;
                            end
                            else if (digit)
                            begin
                                mag_next   = qpie_pkg::MAG_W'(c[3:0]);
                                phase_next = qpie_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = qpie_pkg::PH_STOP;
                            end
                        end
                        qpie_pkg::PH_SIGN, qpie_pkg::PH_DIGITS:
                        begin
                            if (digit)
                            begin
                                mag_next   = (mag_reg << 3) + (mag_reg << 1) +
                                             qpie_pkg::MAG_W'(c[3:0]);
                                phase_next = qpie_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = qpie_pkg::PH_STOP;
                            end
                        end
                        qpie_pkg::PH_STOP:
                        begin
                            phase_next = qpie_pkg::PH_STOP;
                        end
                        default:
                        begin
                            phase_next = qpie_pkg::PH_STOP;
                        end
                    endcase
                end
            end
            else if (seg_reg < klen)
            begin
                if (c != kbyte)
                begin
                    pm_next = 1'b0;
                end
                seg_next = seg_reg + 1'b1;
            end
            else if (seg_reg == klen)
            begin
                if (pm_reg && c == qpie_pkg::CH_EQ)
                begin
                    inval_next = 1'b1;
                end
                seg_next = seg_reg + 1'b1;
            end
        end
    end

    assign mag_ext = {1'b0, mag_next};

    always_comb
    begin
        out_item_next.key_found   = inval_next;
        out_item_next.param_value = '0;
        if (inval_next && cnt_next <= VMAX)
        begin
            out_item_next.param_value = neg_next ? -mag_ext : mag_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg   <= '0;
            pm_reg    <= 1'b1;
            inval_reg <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= qpie_pkg::PH_BLANK;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (hold_take)
        begin
            if (hold_item.last_byte)
            begin
                seg_reg   <= '0;
                pm_reg    <= 1'b1;
                inval_reg <= 1'b0;
                cnt_reg   <= '0;
                phase_reg <= qpie_pkg::PH_BLANK;
                neg_reg   <= 1'b0;
                mag_reg   <= '0;
                done_reg  <= 1'b0;
            end
            else
            begin
                seg_reg   <= seg_next;
                pm_reg    <= pm_next;
                inval_reg <= inval_next;
                cnt_reg   <= cnt_next;
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                mag_reg   <= mag_next;
                done_reg  <= done_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (hold_take && hold_item.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_take && hold_item.last_byte)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= VMAX + 1'b1)
        else $error("value byte count out of range");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !inval_reg |-> (phase_reg == qpie_pkg::PH_BLANK && mag_reg == '0 && cnt_reg == '0))
        else $error("number state set outside value text");

    a_done_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> inval_reg)
        else $error("segment ended without value text");

    a_digits_counted: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == qpie_pkg::PH_DIGITS |-> cnt_reg != '0)
        else $error("digits taken with no value byte counted");

    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        hold_take && hold_item.last_byte |=> out_valid_reg)
        else $error("last byte taken but no result");

endmodule
